>>> rtl/bitmap_frame_allocator_defines.svh
// Assertion macros for the allocator top level.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bfa_pkg.sv
package bfa_pkg;

   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned WORD_SHIFT  = 5;
   localparam int unsigned FRAME_SHIFT = 12;

   localparam logic [12:0] POOL_FRAME_COUNT_RESET = 13'd4096;

   typedef enum logic [2:0] {
      OP_ALLOC       = 3'd0,
      OP_FREE_ADDR   = 3'd1,
      OP_MARK        = 3'd2,
      OP_RELEASE     = 3'd3,
      OP_QUERY_FRAME = 3'd4,
      OP_QUERY_ADDR  = 3'd5,
      OP_REINIT      = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NONE_FREE = 2'd1,
      ST_OUTSIDE   = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_POOL_BASE        = 1'b0,
      CSR_POOL_FRAME_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_ALLOC,
      CMD_SET,
      CMD_CLEAR,
      CMD_QUERY,
      CMD_REINIT,
      CMD_REPLY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      status_type   status;
   } cmd_type;

   typedef struct packed {
      logic [31:0] address;
      logic        is_free;
      status_type  status;
   } rsp_type;

   typedef enum logic [2:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_SCAN,
      BS_READ,
      BS_MODIFY
   } back_state_type;

   typedef struct packed {
      logic       found;
      logic [4:0] pos;
   } zero_search_type;

   // Lowest clear bit of a map word.
   function automatic zero_search_type first_zero(input logic [WORD_BITS-1:0] w);
      zero_search_type r;
      r.found = ~&w;
      r.pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r.pos = 5'(i);
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/bfa_fifo.sv
module bfa_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in;
   logic [AW-1:0]    rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (AW + 1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/bfa_front.sv
module bfa_front #(
   parameter int unsigned MAX_FRAMES = 4096,
   parameter int unsigned FRAME_W    = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [2:0]           operation,
   input  logic [31:0]          byte_address,
   input  logic [11:0]          frame_index,
   input  logic [31:0]          pool_base,
   input  logic [12:0]          pool_frame_count,
   input  logic                 hold,
   input  logic                 cmd_pop,
   output logic                 cmd_valid,
   output bfa_pkg::cmd_type     cmd,
   output logic [FRAME_W-1:0]   cmd_frame
);
   import bfa_pkg::*;

   localparam logic [19:0] MAX_F = 20'(MAX_FRAMES);
   localparam int unsigned QW    = $bits(cmd_type) + FRAME_W;

   op_type         op;
   logic [31:0]    offset;
   logic [19:0]    sel;
   logic           in_range;
   cmd_type        cls;
   logic           q_full, q_empty;
   logic [QW-1:0]  q_rdata;

   assign op     = op_type'(operation);
   assign offset = byte_address - pool_base;
   assign sel    = (op == OP_FREE_ADDR || op == OP_QUERY_ADDR) ?
                   offset[31:FRAME_SHIFT] : 20'(frame_index);
   // A frame is inside the pool when it is below both the written count and the map size.
   assign in_range = (sel < {7'd0, pool_frame_count}) && (sel < MAX_F);

   always_comb begin
      cls.kind   = CMD_REPLY;
      cls.status = ST_OK;
      unique case (op)
         OP_ALLOC: begin
            cls.kind = CMD_ALLOC;
         end
         OP_FREE_ADDR, OP_RELEASE: begin
            cls.kind   = in_range ? CMD_CLEAR : CMD_REPLY;
            cls.status = in_range ? ST_OK : ST_OUTSIDE;
         end
         OP_MARK: begin
            cls.kind   = in_range ? CMD_SET : CMD_REPLY;
            cls.status = in_range ? ST_OK : ST_OUTSIDE;
         end
         OP_QUERY_FRAME, OP_QUERY_ADDR: begin
            cls.kind   = in_range ? CMD_QUERY : CMD_REPLY;
            cls.status = in_range ? ST_OK : ST_OUTSIDE;
         end
         OP_REINIT: begin
            cls.kind = CMD_REINIT;
         end
         default: begin
            cls.kind = CMD_REPLY;
         end
      endcase
   end

   assign full = q_full || hold;

   bfa_fifo #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (push && !hold),
      .wdata ({cls, sel[FRAME_W-1:0]}),
      .full  (q_full),
      .pop   (cmd_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign cmd_valid = !q_empty;
   assign cmd       = cmd_type'(q_rdata[QW-1:FRAME_W]);
   assign cmd_frame = q_rdata[FRAME_W-1:0];

endmodule

>>> rtl/bfa_back.sv
module bfa_back #(
   parameter int unsigned MAX_FRAMES = 4096,
   parameter int unsigned FRAME_W    = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  bfa_pkg::cmd_type     cmd,
   input  logic [FRAME_W-1:0]   cmd_frame,
   output logic                 cmd_pop,
   input  logic [31:0]          pool_base,
   input  logic [12:0]          pool_frame_count,
   input  logic                 rsp_space,
   output logic                 rsp_push,
   output bfa_pkg::rsp_type     rsp,
   output logic                 clearing
);
   import bfa_pkg::*;

   localparam int unsigned WORDS    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WORD_AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned CHUNKS   = (WORDS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned CHUNK_AW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam logic [19:0] MAX_F    = 20'(MAX_FRAMES);

   logic [WORD_BITS-1:0] mem [WORDS];

   back_state_type          state_ff, state_in;
   logic [WORD_AW-1:0]      clr_ff, clr_in;
   logic                    reinit_ff, reinit_in;
   logic [CHUNK_AW-1:0]     chunk_ff, chunk_in;
   logic [WORD_AW-1:0]      word_ff, word_in;
   logic [4:0]              bit_ff, bit_in;
   cmd_kind_type            kind_ff, kind_in;
   logic [WORD_BITS-1:0]    rd_data_ff;
   logic [WORDS-1:0]        sum_ff;

   logic                    start;
   logic                    clr_last, chunk_last;
   logic [CHUNKS*WORD_BITS-1:0] sum_pad;
   logic [WORD_BITS-1:0]    chunk_bits;
   zero_search_type         zs_sum, zs_word;
   logic [CHUNK_AW+4:0]     found_ext;
   logic [FRAME_W-1:0]      alloc_frame;
   logic                    alloc_ok;
   logic [4:0]              target_bit;
   logic [WORD_BITS-1:0]    bit_mask, new_word;
   logic                    mem_we;
   logic [WORD_AW-1:0]      mem_wa;
   logic [WORD_BITS-1:0]    mem_wd;
   logic                    sum_we, sum_clear;

   assign start      = (state_ff == BS_IDLE) && cmd_valid && rsp_space;
   assign clr_last   = (clr_ff == WORD_AW'(WORDS - 1));
   assign chunk_last = (chunk_ff == CHUNK_AW'(CHUNKS - 1));
   assign clearing   = (state_ff == BS_CLEAR);

   // Padding words beyond the map read as full so the search never lands there.
   always_comb begin
      sum_pad              = '1;
      sum_pad[WORDS-1:0]   = sum_ff;
   end

   assign chunk_bits  = sum_pad[chunk_ff*WORD_BITS +: WORD_BITS];
   assign zs_sum      = first_zero(chunk_bits);
   assign found_ext   = {chunk_ff, zs_sum.pos};
   assign zs_word     = first_zero(rd_data_ff);
   assign alloc_frame = {word_ff, zs_word.pos};
   assign alloc_ok    = (20'(alloc_frame) < {7'd0, pool_frame_count}) &&
                        (20'(alloc_frame) < MAX_F);
   assign target_bit  = (kind_ff == CMD_ALLOC) ? zs_word.pos : bit_ff;
   assign bit_mask    = WORD_BITS'(1) << target_bit;
   assign new_word    = (kind_ff == CMD_CLEAR) ? (rd_data_ff & ~bit_mask)
                                               : (rd_data_ff | bit_mask);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BS_CLEAR: begin
            if (clr_last) begin
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: begin
            if (start) begin
               unique case (cmd.kind)
                  CMD_ALLOC:                      state_in = BS_SCAN;
                  CMD_SET, CMD_CLEAR, CMD_QUERY:  state_in = BS_READ;
                  CMD_REINIT:                     state_in = BS_CLEAR;
                  default:                        state_in = BS_IDLE;
               endcase
            end
         end
         BS_SCAN: begin
            if (zs_sum.found) begin
               state_in = BS_READ;
            end else if (chunk_last) begin
               state_in = BS_IDLE;
            end
         end
         BS_READ: begin
            state_in = BS_MODIFY;
         end
         BS_MODIFY: begin
            state_in = BS_IDLE;
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   // Outputs and datapath controls.
   always_comb begin
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp.address = '0;
      rsp.is_free = 1'b0;
      rsp.status  = ST_OK;
      mem_we      = 1'b0;
      mem_wa      = word_ff;
      mem_wd      = new_word;
      sum_we      = 1'b0;
      sum_clear   = 1'b0;
      clr_in      = clr_ff;
      reinit_in   = reinit_ff;
      chunk_in    = chunk_ff;
      word_in     = word_ff;
      bit_in      = bit_ff;
      kind_in     = kind_ff;
      unique case (state_ff)
         BS_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = (clr_ff == '0) ? WORD_BITS'(1) : '0;
            clr_in = clr_ff + 1'b1;
            if (clr_last) begin
               rsp_push  = reinit_ff;
               reinit_in = 1'b0;
            end
         end
         BS_IDLE: begin
            if (start) begin
               cmd_pop   = 1'b1;
               word_in   = cmd_frame[FRAME_W-1:WORD_SHIFT];
               bit_in    = cmd_frame[WORD_SHIFT-1:0];
               kind_in   = cmd.kind;
               chunk_in  = '0;
               clr_in    = '0;
               reinit_in = (cmd.kind == CMD_REINIT);
               sum_clear = (cmd.kind == CMD_REINIT);
               if (cmd.kind == CMD_REPLY) begin
                  rsp_push   = 1'b1;
                  rsp.status = cmd.status;
               end
            end
         end
         BS_SCAN: begin
            if (zs_sum.found) begin
               word_in = found_ext[WORD_AW-1:0];
            end else begin
               chunk_in = chunk_ff + 1'b1;
               if (chunk_last) begin
                  rsp_push   = 1'b1;
                  rsp.status = ST_NONE_FREE;
               end
            end
         end
         BS_READ: begin
         end
         BS_MODIFY: begin
            rsp_push = 1'b1;
            unique case (kind_ff)
               CMD_ALLOC: begin
                  if (alloc_ok) begin
                     mem_we      = 1'b1;
                     sum_we      = 1'b1;
                     rsp.address = 32'({alloc_frame, FRAME_SHIFT'(0)}) + pool_base;
                  end else begin
                     rsp.status = ST_NONE_FREE;
                  end
               end
               CMD_SET, CMD_CLEAR: begin
                  mem_we = 1'b1;
                  sum_we = 1'b1;
               end
               CMD_QUERY: begin
                  rsp.is_free = ~rd_data_ff[bit_ff];
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BS_CLEAR;
         clr_ff    <= '0;
         reinit_ff <= 1'b0;
         chunk_ff  <= '0;
         sum_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         reinit_ff <= reinit_in;
         chunk_ff  <= chunk_in;
         if (sum_clear) begin
            sum_ff <= '0;
         end else if (sum_we) begin
            sum_ff[word_ff] <= &new_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      bit_ff  <= bit_in;
      kind_ff <= kind_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[word_ff];
   end

endmodule

>>> rtl/bitmap_frame_allocator.sv
// Channel    Direction  Handshake              Carries
// request    in         req_push / req_full    operation, byte address, frame index
// response   out        rsp_empty / rsp_pop    result address, is_free, status
// csr        in         csr_write_enable       pool base, pool frame count
//
// Allocate searches the full-word summary 32 words per cycle, then reads and writes one map word.
// Mark, release and query pass through the map memory in a read state and then a modify state; a
// request outside the pool or with an unknown operation is answered from the idle state. Reinitialise
// and reset sweep the map one word per cycle, with req_full held high.
// Two-entry queues on both sides let requests queue up while responses wait to be popped.
`include "bitmap_frame_allocator_defines.svh"

module bitmap_frame_allocator #(
   parameter int unsigned MAX_FRAMES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_byte_address,
   input  logic [11:0] req_frame_index,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_result_address,
   output logic        rsp_is_free,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import bfa_pkg::*;

   localparam int unsigned WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned FRAME_W = WORD_AW + WORD_SHIFT;

   logic [31:0]        pool_base_ff;
   logic [12:0]        pool_frame_count_ff;
   logic               cmd_valid, cmd_pop, clearing;
   cmd_type            cmd;
   logic [FRAME_W-1:0] cmd_frame;
   logic               rsp_push, rsp_full_int;
   rsp_type            rsp_in, rsp_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff        <= '0;
         pool_frame_count_ff <= POOL_FRAME_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_POOL_BASE:        pool_base_ff        <= csr_write_data;
            CSR_POOL_FRAME_COUNT: pool_frame_count_ff <= csr_write_data[12:0];
            default: begin
            end
         endcase
      end
   end

   bfa_front #(
      .MAX_FRAMES (MAX_FRAMES),
      .FRAME_W    (FRAME_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (req_push),
      .full             (req_full),
      .operation        (req_operation),
      .byte_address     (req_byte_address),
      .frame_index      (req_frame_index),
      .pool_base        (pool_base_ff),
      .pool_frame_count (pool_frame_count_ff),
      .hold             (clearing),
      .cmd_pop          (cmd_pop),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_frame        (cmd_frame)
   );

   bfa_back #(
      .MAX_FRAMES (MAX_FRAMES),
      .FRAME_W    (FRAME_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_frame        (cmd_frame),
      .cmd_pop          (cmd_pop),
      .pool_base        (pool_base_ff),
      .pool_frame_count (pool_frame_count_ff),
      .rsp_space        (!rsp_full_int),
      .rsp_push         (rsp_push),
      .rsp              (rsp_in),
      .clearing         (clearing)
   );

   bfa_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_in),
      .full  (rsp_full_int),
      .pop   (rsp_pop),
      .rdata (rsp_out),
      .empty (rsp_empty)
   );

   assign rsp_result_address = rsp_out.address;
   assign rsp_is_free        = rsp_out.is_free;
   assign rsp_status         = rsp_out.status;

   `BFA_ASSERT_SAME(a_rsp_room, clock, reset, rsp_push, !rsp_full_int, "response pushed into a full queue")
   `BFA_ASSERT_SAME(a_cmd_avail, clock, reset, cmd_pop, cmd_valid, "request popped from an empty queue")
   `BFA_ASSERT_SAME(a_clear_hold, clock, reset, clearing, req_full, "request taken while the map is swept")
   `BFA_ASSERT_NEXT(a_rsp_shown, clock, reset, rsp_push, !rsp_empty, "pushed response not visible")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import bfa_pkg::*;

   localparam int unsigned MAP_FRAMES   = 4096;
   localparam logic [31:0] FRAME_BYTES  = 32'h0000_1000;
   localparam logic [2:0]  OP_UNDEFINED = 3'd7;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_push           = 1'b0;
   logic        req_full;
   logic [2:0]  req_operation      = '0;
   logic [31:0] req_byte_address   = '0;
   logic [11:0] req_frame_index    = '0;
   logic        rsp_empty;
   logic        rsp_pop            = 1'b0;
   logic [31:0] rsp_result_address;
   logic        rsp_is_free;
   logic [1:0]  rsp_status;
   logic        csr_write_enable   = 1'b0;
   logic [0:0]  csr_index          = '0;
   logic [31:0] csr_write_data     = '0;

   // Shadow copy of the pool registers and the used map.
   logic [31:0]           pool_base_shadow   = '0;
   logic [12:0]           frame_count_shadow = POOL_FRAME_COUNT_RESET;
   logic [MAP_FRAMES-1:0] frame_used         = MAP_FRAMES'(1);

   rsp_type expected_replies[$];
   int      error_count = 0;
   bit      push_idle   = 1'b0;
   bit      pop_idle    = 1'b0;

   bitmap_frame_allocator #(
      .MAX_FRAMES(MAP_FRAMES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_operation      (req_operation),
      .req_byte_address   (req_byte_address),
      .req_frame_index    (req_frame_index),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_result_address (rsp_result_address),
      .rsp_is_free        (rsp_is_free),
      .rsp_status         (rsp_status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned active_frames();
      return (frame_count_shadow > 13'd4096) ? MAP_FRAMES : 32'(frame_count_shadow);
   endfunction

   function automatic rsp_type predict_reply(logic [2:0] op, logic [31:0] addr,
                                             logic [11:0] fidx);
      rsp_type     reply;
      int unsigned limit;
      logic [31:0] addr_frame;
      logic        found;
      reply.address = '0;
      reply.is_free = 1'b0;
      reply.status  = ST_OK;
      limit         = active_frames();
      addr_frame    = (addr - pool_base_shadow) >> FRAME_SHIFT;
      found         = 1'b0;
      case (op)
         OP_ALLOC: begin
            reply.status = ST_NONE_FREE;
            for (int f = 0; f < limit; f++) begin
               if (!found && !frame_used[f]) begin
                  found         = 1'b1;
                  frame_used[f] = 1'b1;
                  reply.address = pool_base_shadow + FRAME_BYTES * 32'(f);
                  reply.status  = ST_OK;
               end
            end
         end
         OP_FREE_ADDR: begin
            if (addr_frame < limit) frame_used[addr_frame[11:0]] = 1'b0;
            else reply.status = ST_OUTSIDE;
         end
         OP_MARK: begin
            if (fidx < limit) frame_used[fidx] = 1'b1;
            else reply.status = ST_OUTSIDE;
         end
         OP_RELEASE: begin
            if (fidx < limit) frame_used[fidx] = 1'b0;
            else reply.status = ST_OUTSIDE;
         end
         OP_QUERY_FRAME: begin
            if (fidx < limit) reply.is_free = ~frame_used[fidx];
            else reply.status = ST_OUTSIDE;
         end
         OP_QUERY_ADDR: begin
            if (addr_frame < limit) reply.is_free = ~frame_used[addr_frame[11:0]];
            else reply.status = ST_OUTSIDE;
         end
         OP_REINIT: begin
            frame_used    = '0;
            frame_used[0] = 1'b1;
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   // Mostly frames near the bottom of the pool, where allocations land.
   function automatic logic [19:0] pick_frame();
      int unsigned span;
      span = (active_frames() < 80) ? active_frames() : 80;
      case ($urandom_range(9))
         0:       return 20'($urandom_range(4095));
         1:       return 20'($urandom);
         default: return 20'($urandom_range(span + 1));
      endcase
   endfunction

   task automatic send_request(logic [2:0] op, logic [31:0] addr, logic [11:0] fidx);
      int gap;
      gap = push_idle ? $urandom_range(4) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_operation    <= op;
      req_byte_address <= addr;
      req_frame_index  <= fidx;
      do @(posedge clock); while (req_full !== 1'b0);
      expected_replies.push_back(predict_reply(op, addr, fidx));
   endtask

   task automatic drain_replies();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_pool(logic [31:0] base, logic [12:0] count);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_POOL_BASE;
      csr_write_data   <= base;
      @(posedge clock);
      csr_index        <= CSR_POOL_FRAME_COUNT;
      csr_write_data   <= 32'(count);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pool_base_shadow   = base;
      frame_count_shadow = count;
   endtask

   task automatic send_random_request();
      int unsigned pick;
      logic [19:0] frame;
      logic [31:0] addr;
      pick  = $urandom_range(99);
      frame = pick_frame();
      addr  = pool_base_shadow + {frame, 12'($urandom)};
      if (pick < 35)      send_request(OP_ALLOC, $urandom, 12'($urandom));
      else if (pick < 55) send_request(OP_FREE_ADDR, addr, 12'($urandom));
      else if (pick < 65) send_request(OP_MARK, $urandom, frame[11:0]);
      else if (pick < 75) send_request(OP_RELEASE, $urandom, frame[11:0]);
      else if (pick < 85) send_request(OP_QUERY_FRAME, $urandom, frame[11:0]);
      else if (pick < 93) send_request(OP_QUERY_ADDR, addr, 12'($urandom));
      else if (pick < 95) send_request(OP_REINIT, $urandom, 12'($urandom));
      else if (pick < 97) send_request(OP_UNDEFINED, $urandom, 12'($urandom));
      else                send_request(3'($urandom), $urandom, 12'($urandom));
   endtask

   task automatic test_reset_state();
      send_request(OP_QUERY_FRAME, '0, 12'd0);
      send_request(OP_QUERY_FRAME, '0, 12'd4095);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_QUERY_ADDR, 32'h0000_1FFF, '0);
      send_request(OP_RELEASE, '0, 12'd0);
      // With frame 0 released at base 0, allocate gives address 0 and status ok.
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_FREE_ADDR, 32'hFFFF_FFFF, '0);
      send_request(OP_QUERY_ADDR, 32'hFFFF_FFFF, 12'hFFF);
      send_request(OP_MARK, '0, 12'd4095);
      send_request(OP_QUERY_FRAME, '0, 12'd4095);
      send_request(OP_RELEASE, '0, 12'd4095);
      send_request(OP_UNDEFINED, 32'hFFFF_FFFF, 12'hFFF);
      send_request(OP_FREE_ADDR, 32'h0000_1000, '0);
      send_request(OP_REINIT, '0, '0);
      send_request(OP_QUERY_FRAME, '0, 12'd1);
   endtask

   task automatic test_pool_extremes();
      drain_replies();
      write_pool(32'hFFFF_F000, 13'd1);
      send_request(OP_REINIT, '0, '0);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_RELEASE, '0, 12'd0);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_QUERY_ADDR, 32'h0000_0000, '0);
      send_request(OP_MARK, '0, 12'd1);
      drain_replies();
      // An empty pool: nothing can be allocated and every frame is outside.
      write_pool(32'hFFFF_F000, 13'd0);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_QUERY_FRAME, '0, 12'd0);
      send_request(OP_REINIT, '0, '0);
      drain_replies();
      write_pool(32'h0000_0ABC, 13'd8191);
      send_request(OP_QUERY_ADDR, 32'h0000_0ABB, '0);
      send_request(OP_QUERY_ADDR, 32'h0000_1ABB, '0);
      send_request(OP_MARK, '0, 12'd4095);
      send_request(OP_ALLOC, '0, '0);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         drain_replies();
         case (phase)
            0:       write_pool(32'h0000_0000, 13'd4096);
            1:       write_pool(32'hFFFF_FFFF, 13'd8191);
            2:       write_pool($urandom & 32'hFFFF_F000, 13'($urandom_range(8191, 4097)));
            3:       write_pool($urandom, 13'd1);
            default: write_pool($urandom_range(1) ? $urandom : ($urandom & 32'hFFFF_F000),
                                13'($urandom_range(64, 2)));
         endcase
         push_idle = ($urandom_range(2) != 0);
         pop_idle  = ($urandom_range(2) != 0);
         for (int n = 0; n < 185; n++) begin
            if ($urandom_range(60) == 0) drain_replies();
            send_random_request();
         end
      end
   endtask

   initial begin : reply_checker
      int      stall;
      rsp_type want;
      forever begin
         stall = pop_idle ? $urandom_range(4) : 0;
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (reset || rsp_empty !== 1'b0);
         if (expected_replies.size() == 0) begin
            $display("%0t: response with nothing expected: address %h is_free %b status %0d",
                     $time, rsp_result_address, rsp_is_free, rsp_status);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_result_address !== want.address) begin
               $display("%0t: result_address expected %h, got %h",
                        $time, want.address, rsp_result_address);
               error_count++;
            end
            if (rsp_is_free !== want.is_free) begin
               $display("%0t: is_free expected %b, got %b", $time, want.is_free, rsp_is_free);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_pool_extremes();
      test_random_traffic();
      drain_replies();
      // Give a trailing map sweep time to finish before the final verdict.
      repeat (200) @(posedge clock);
      if (expected_replies.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_replies.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_fifo.sv
rtl/bfa_front.sv
rtl/bfa_back.sv
rtl/bitmap_frame_allocator.sv
bench/tb.sv
